// File: design/pfg_pkg.sv
package pfg_pkg;

   // field widths
   localparam int unsigned TICKS_W  = 8;
   localparam int unsigned FRAME_W  = 16;
   localparam int unsigned PULSE_W  = 12;
   localparam int unsigned CHIDX_W  = 3;
   localparam int unsigned CHUS_W   = 12;
   localparam int unsigned LOW_W    = 24;
   localparam int unsigned PERIOD_W = 25;
   localparam int unsigned SLOT_W   = 4;
   localparam int unsigned ACC_W    = 17;
   localparam int unsigned LOWUS_W  = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // reset values
   localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd42;
   localparam logic [FRAME_W-1:0] FRAME_RESET = 16'd20000;
   localparam logic [PULSE_W-1:0] PULSE_RESET = 12'd400;
   localparam logic [CHUS_W-1:0]  CHUS_RESET  = 12'd600;

   // saturation ceiling of the frame total
   localparam logic [ACC_W-1:0] ACC_MAX = '1;

   typedef enum logic [0:0] {
      OP_EVENT = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TICKS_PER_US    = 2'd0,
      REG_FRAME_LENGTH_US = 2'd1,
      REG_PULSE_US        = 2'd2
   } reg_idx_type;

endpackage

// File: design/pfg_req_if.sv
interface pfg_req_if;
   logic                                valid;
   logic                                ready;
   pfg_pkg::op_type                     operation;
   logic [pfg_pkg::CHIDX_W-1:0]         channel_index;
   logic [pfg_pkg::CHUS_W-1:0]          channel_us;

   modport source (output valid, operation, channel_index, channel_us, input ready);
   modport sink   (input valid, operation, channel_index, channel_us, output ready);
endinterface

// File: design/pfg_rsp_if.sv
interface pfg_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pfg_pkg::LOW_W-1:0]           low_ticks;
   logic [pfg_pkg::PERIOD_W-1:0]        period_ticks;
   logic [pfg_pkg::SLOT_W-1:0]          slot;
   logic                                is_sync;

   modport source (output valid, low_ticks, period_ticks, slot, is_sync, input ready);
   modport sink   (input valid, low_ticks, period_ticks, slot, is_sync, output ready);
endinterface

// File: design/ppm_frame_generator_unit.sv
// a period-end event's result is registered in the schedule stage and then in the result stage before it appears on rsp
// throughput: one item per cycle; slot scheduling and the two tick products each take
// one register stage, and a stalled result holds both stages and the input
// writes update the channel store at acceptance and produce no result
// reset (synchronous, active high): registers to defaults, every channel to 600 us,
// slot counter and frame total to zero, pipeline empty
module ppm_frame_generator_unit #(
   parameter int unsigned CHANNELS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   pfg_req_if.sink                          req,
   pfg_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [pfg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pfg_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned CNT_W = $clog2(CHANNELS + 1);
   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned WIDE_W = pfg_pkg::SLOT_W + 1;

   // configuration registers
   logic [pfg_pkg::TICKS_W-1:0] ticks_ff;
   logic [pfg_pkg::FRAME_W-1:0] frame_ff;
   logic [pfg_pkg::PULSE_W-1:0] pulse_ff;

   // frame state
   logic [pfg_pkg::CHUS_W-1:0]  store_ff [CHANNELS];
   logic [pfg_pkg::CHUS_W-1:0]  store_in [CHANNELS];
   logic [CNT_W-1:0]            slot_ff, slot_in;
   logic [pfg_pkg::ACC_W-1:0]   acc_ff, acc_in;

   // schedule stage
   logic                        a_valid_ff, a_valid_in;
   logic [pfg_pkg::LOWUS_W-1:0] a_low_us_ff, a_low_us_in;
   logic [pfg_pkg::SLOT_W-1:0]  a_slot_ff, a_slot_in;
   logic                        a_sync_ff, a_sync_in;

   // result stage
   logic                         b_valid_ff, b_valid_in;
   logic [pfg_pkg::LOW_W-1:0]    b_low_ff, b_low_in;
   logic [pfg_pkg::PERIOD_W-1:0] b_period_ff, b_period_in;
   logic [pfg_pkg::SLOT_W-1:0]   b_slot_ff, b_slot_in;
   logic                         b_sync_ff, b_sync_in;

   // handshake and scheduling signals
   logic                        b_ready, a_ready;
   logic                        req_fire, event_fire, write_fire;
   logic                        sync_now;
   logic [WIDE_W-1:0]           slot_wide;
   logic [pfg_pkg::CHUS_W-1:0]  chan_us;
   logic [pfg_pkg::LOWUS_W-1:0] gap_us;
   logic [pfg_pkg::ACC_W:0]     sum_chan, sum_pulse;
   logic [pfg_pkg::ACC_W-1:0]   acc_chan;
   logic [pfg_pkg::LOW_W-1:0]   low_prod;
   logic [pfg_pkg::LOW_W-1:0]   pulse_prod;

   // pipeline flow control
   assign b_ready    = !b_valid_ff || rsp.ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign req.ready  = a_ready;
   assign req_fire   = req.valid && a_ready;
   assign event_fire = req_fire && (req.operation == pfg_pkg::OP_EVENT);
   assign write_fire = req_fire && (req.operation == pfg_pkg::OP_WRITE);

   // slot selection and sync gap
   assign sync_now  = slot_ff >= CNT_W'(CHANNELS);
   assign slot_wide = WIDE_W'(slot_ff);
   assign chan_us   = store_ff[slot_ff[IDX_W-1:0]];
   assign gap_us    = ({1'b0, frame_ff} <= acc_ff) ? '0
                      : pfg_pkg::LOWUS_W'({1'b0, frame_ff} - acc_ff);

   // saturating frame total
   assign sum_chan  = {1'b0, acc_ff} + (pfg_pkg::ACC_W + 1)'(chan_us);
   assign acc_chan  = sum_chan[pfg_pkg::ACC_W] ? pfg_pkg::ACC_MAX
                      : sum_chan[pfg_pkg::ACC_W-1:0];
   assign sum_pulse = (sync_now ? '0 : {1'b0, acc_chan})
                      + (pfg_pkg::ACC_W + 1)'(pulse_ff);

   // channel store writes
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         store_in[i] = store_ff[i];
         if (write_fire && (8'(req.channel_index) == 8'(i))) begin
            store_in[i] = req.channel_us;
         end
      end
   end

   // slot scheduling
   always_comb begin
      slot_in     = slot_ff;
      acc_in      = acc_ff;
      a_valid_in  = a_ready ? event_fire : a_valid_ff;
      a_low_us_in = a_low_us_ff;
      a_slot_in   = a_slot_ff;
      a_sync_in   = a_sync_ff;
      if (event_fire) begin
         slot_in     = sync_now ? '0 : slot_ff + CNT_W'(1);
         acc_in      = sum_pulse[pfg_pkg::ACC_W] ? pfg_pkg::ACC_MAX
                       : sum_pulse[pfg_pkg::ACC_W-1:0];
         a_low_us_in = sync_now ? gap_us : pfg_pkg::LOWUS_W'(chan_us);
         a_slot_in   = slot_wide[pfg_pkg::SLOT_W-1:0];
         a_sync_in   = sync_now;
      end
   end

   // tick products
   assign low_prod   = pfg_pkg::LOW_W'(a_low_us_ff) * pfg_pkg::LOW_W'(ticks_ff);
   assign pulse_prod = pfg_pkg::LOW_W'(pulse_ff) * pfg_pkg::LOW_W'(ticks_ff);

   // result register
   always_comb begin
      b_valid_in  = b_ready ? a_valid_ff : b_valid_ff;
      b_low_in    = b_low_ff;
      b_period_in = b_period_ff;
      b_slot_in   = b_slot_ff;
      b_sync_in   = b_sync_ff;
      if (b_ready && a_valid_ff) begin
         b_low_in    = low_prod;
         b_period_in = pfg_pkg::PERIOD_W'(low_prod) + pfg_pkg::PERIOD_W'(pulse_prod);
         b_slot_in   = a_slot_ff;
         b_sync_in   = a_sync_ff;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= pfg_pkg::TICKS_RESET;
         frame_ff <= pfg_pkg::FRAME_RESET;
         pulse_ff <= pfg_pkg::PULSE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            pfg_pkg::REG_TICKS_PER_US:    ticks_ff <= csr_wdata[pfg_pkg::TICKS_W-1:0];
            pfg_pkg::REG_FRAME_LENGTH_US: frame_ff <= csr_wdata[pfg_pkg::FRAME_W-1:0];
            pfg_pkg::REG_PULSE_US:        pulse_ff <= csr_wdata[pfg_pkg::PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   // state and pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            store_ff[i] <= pfg_pkg::CHUS_RESET;
         end
         slot_ff    <= '0;
         acc_ff     <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         store_ff   <= store_in;
         slot_ff    <= slot_in;
         acc_ff     <= acc_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
      a_low_us_ff <= a_low_us_in;
      a_slot_ff   <= a_slot_in;
      a_sync_ff   <= a_sync_in;
      b_low_ff    <= b_low_in;
      b_period_ff <= b_period_in;
      b_slot_ff   <= b_slot_in;
      b_sync_ff   <= b_sync_in;
   end

   // result port
   assign rsp.valid        = b_valid_ff;
   assign rsp.low_ticks    = b_low_ff;
   assign rsp.period_ticks = b_period_ff;
   assign rsp.slot         = b_slot_ff;
   assign rsp.is_sync      = b_sync_ff;

   // checks
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= CNT_W'(CHANNELS))
      else $error("slot counter beyond sync slot");

   a_event_enters: assert property (@(posedge clock) disable iff (reset)
      event_fire |=> a_valid_ff)
      else $error("accepted event lost at schedule stage");

   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (write_fire && a_ready) |=> !a_valid_ff)
      else $error("write item produced a result");

   a_sync_wraps: assert property (@(posedge clock) disable iff (reset)
      (event_fire && sync_now) |=> (slot_ff == '0))
      else $error("slot counter did not wrap after sync");

   a_period_order: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> (pfg_pkg::PERIOD_W'(b_low_ff) <= b_period_ff))
      else $error("period shorter than low time");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned CHANNELS    = 8;
   localparam int unsigned QUIET_LIMIT = 400;
   localparam int unsigned DRAIN_WAIT  = 4;

   typedef struct packed {
      logic [pfg_pkg::LOW_W-1:0]    low_ticks;
      logic [pfg_pkg::PERIOD_W-1:0] period_ticks;
      logic [pfg_pkg::SLOT_W-1:0]   slot;
      logic                         is_sync;
   } slot_rec_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [pfg_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [pfg_pkg::CSR_DATA_W-1:0] csr_wdata;

   pfg_req_if req_if ();
   pfg_rsp_if rsp_if ();

   ppm_frame_generator_unit #(
      .CHANNELS (CHANNELS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the frame generator: timing registers and slot state
   int unsigned tick_rate;
   int unsigned frame_len;
   int unsigned sep_pulse;
   int unsigned chan_width [CHANNELS];
   int unsigned slot_pos;
   int unsigned frame_total;

   slot_rec_type pending_slots [$];
   int unsigned fail_count;
   bit src_idle;
   bit sink_idle;

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int unsigned add_capped(int unsigned a, int unsigned b);
      int unsigned s;
      s = a + b;
      return (s > pfg_pkg::ACC_MAX) ? pfg_pkg::ACC_MAX : s;
   endfunction

   // next slot's compare values, advancing the shadow state
   function automatic slot_rec_type schedule_slot();
      slot_rec_type r;
      int unsigned  low_us;
      int unsigned  low_t;
      int unsigned  per_t;
      if (slot_pos >= CHANNELS) begin
         // sync gap fills the rest of the frame, floored at zero on overrun
         low_us = (frame_total >= frame_len) ? 0 : frame_len - frame_total;
         frame_total = 0;
         slot_pos = 0;
         r.slot = pfg_pkg::SLOT_W'(CHANNELS);
         r.is_sync = 1'b1;
      end else begin
         low_us = chan_width[slot_pos];
         frame_total = add_capped(frame_total, low_us);
         r.slot = pfg_pkg::SLOT_W'(slot_pos);
         r.is_sync = 1'b0;
         slot_pos = slot_pos + 1;
      end
      frame_total = add_capped(frame_total, sep_pulse);
      low_t = low_us * tick_rate;
      per_t = low_t + sep_pulse * tick_rate;
      r.low_ticks = pfg_pkg::LOW_W'(low_t);
      r.period_ticks = pfg_pkg::PERIOD_W'(per_t);
      return r;
   endfunction

   // send one item, predicting on acceptance
   task automatic send_item(pfg_pkg::op_type op, logic [pfg_pkg::CHIDX_W-1:0] idx,
                            logic [pfg_pkg::CHUS_W-1:0] us);
      int unsigned gap;
      gap = src_idle ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.operation <= op;
      req_if.channel_index <= idx;
      req_if.channel_us <= us;
      do @(posedge clock); while (!req_if.ready);
      if (op == pfg_pkg::OP_WRITE) begin
         chan_width[idx] = us;
      end else begin
         pending_slots.push_back(schedule_slot());
      end
   endtask

   // stop sending and wait until every slot has come out
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_slots.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // write all three timing registers while the block is idle
   task automatic program_timing(int unsigned ticks, int unsigned frame, int unsigned pulse);
      drain();
      csr_we <= 1'b1;
      csr_index <= pfg_pkg::REG_TICKS_PER_US;
      csr_wdata <= pfg_pkg::CSR_DATA_W'(ticks);
      @(negedge clock);
      csr_index <= pfg_pkg::REG_FRAME_LENGTH_US;
      csr_wdata <= pfg_pkg::CSR_DATA_W'(frame);
      @(negedge clock);
      csr_index <= pfg_pkg::REG_PULSE_US;
      csr_wdata <= pfg_pkg::CSR_DATA_W'(pulse);
      @(negedge clock);
      csr_we <= 1'b0;
      tick_rate = ticks & 32'hFF;
      frame_len = frame & 32'hFFFF;
      sep_pulse = pulse & 32'hFFF;
   endtask

   // a whole frame from reset values
   task automatic test_reset_frame();
      repeat (CHANNELS + 1) send_item(pfg_pkg::OP_EVENT, '0, '0);
   endtask

   // extreme widths and timings, channels overrunning a short frame
   task automatic test_overrun_extremes();
      program_timing(255, 1000, 4095);
      send_item(pfg_pkg::OP_WRITE, 3'd0, 12'd0);
      send_item(pfg_pkg::OP_WRITE, 3'd1, 12'd4095);
      send_item(pfg_pkg::OP_WRITE, 3'd2, 12'hAAA);
      send_item(pfg_pkg::OP_WRITE, 3'd3, 12'h555);
      repeat (CHANNELS + 1) send_item(pfg_pkg::OP_EVENT, '0, '0);
   endtask

   // zero tick rate gives zero compare values
   task automatic test_zero_tick_rate();
      program_timing(0, 65535, 0);
      send_item(pfg_pkg::OP_WRITE, 3'd7, 12'd4095);
      repeat (2) send_item(pfg_pkg::OP_EVENT, 3'd7, 12'd4095);
   endtask

   // random timings, mostly slot events with writes mixed in
   task automatic test_random_traffic();
      int unsigned ticks;
      int unsigned frame;
      int unsigned pulse;
      logic [pfg_pkg::CHUS_W-1:0] us;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 5))
            0: ticks = 1;
            1: ticks = 255;
            2: ticks = 0;
            default: ticks = $urandom_range(1, 255);
         endcase
         case ($urandom_range(0, 4))
            0: frame = 0;
            1: frame = 65535;
            2: frame = $urandom_range(0, 65535);
            default: frame = $urandom_range(5000, 25000);
         endcase
         case ($urandom_range(0, 3))
            0: pulse = 0;
            1: pulse = 4095;
            default: pulse = $urandom_range(0, 1000);
         endcase
         program_timing(ticks, frame, pulse);
         src_idle = ($urandom_range(0, 3) != 0);
         sink_idle = ($urandom_range(0, 3) != 0);
         for (int n = 0; n < 125; n++) begin
            if ($urandom_range(0, 4) == 0) begin
               case ($urandom_range(0, 5))
                  0: us = '0;
                  1: us = '1;
                  2: us = pfg_pkg::CHUS_W'($urandom);
                  default: us = pfg_pkg::CHUS_W'($urandom_range(500, 2500));
               endcase
               send_item(pfg_pkg::OP_WRITE, pfg_pkg::CHIDX_W'($urandom), us);
            end else begin
               send_item(pfg_pkg::OP_EVENT, pfg_pkg::CHIDX_W'($urandom),
                         pfg_pkg::CHUS_W'($urandom));
            end
         end
      end
   endtask

   // result side: random stalls, compare with the oldest predicted slot
   initial begin
      slot_rec_type want;
      slot_rec_type got;
      int unsigned  stall;
      rsp_if.ready = 1'b0;
      @(negedge reset);
      forever begin
         stall = sink_idle ? $urandom_range(0, 5) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got.low_ticks = rsp_if.low_ticks;
         got.period_ticks = rsp_if.period_ticks;
         got.slot = rsp_if.slot;
         got.is_sync = rsp_if.is_sync;
         if (pending_slots.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected slot: low %0d period %0d slot %0d sync %0b",
                        got.low_ticks, got.period_ticks, got.slot, got.is_sync);
         end else begin
            want = pending_slots.pop_front();
            if (got.low_ticks !== want.low_ticks || got.period_ticks !== want.period_ticks ||
                got.slot !== want.slot || got.is_sync !== want.is_sync) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("slot mismatch: expected low %0d period %0d slot %0d sync %0b",
                           want.low_ticks, want.period_ticks, want.slot, want.is_sync);
                  $display("               got      low %0d period %0d slot %0d sync %0b",
                           got.low_ticks, got.period_ticks, got.slot, got.is_sync);
               end
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_we)
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // reset, then the tests in turn
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = pfg_pkg::REG_TICKS_PER_US;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.operation = pfg_pkg::OP_EVENT;
      req_if.channel_index = '0;
      req_if.channel_us = '0;
      fail_count = 0;
      src_idle = 1'b1;
      sink_idle = 1'b1;
      tick_rate = pfg_pkg::TICKS_RESET;
      frame_len = pfg_pkg::FRAME_RESET;
      sep_pulse = pfg_pkg::PULSE_RESET;
      for (int i = 0; i < CHANNELS; i++) chan_width[i] = pfg_pkg::CHUS_RESET;
      slot_pos = 0;
      frame_total = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_frame();
      test_overrun_extremes();
      test_zero_tick_rate();
      test_random_traffic();
      drain();

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
